### hw/rtl/sbpf_pkg.sv
package sbpf_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int ACT_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CRC_W     = 16;
    localparam int LEN_W     = 16;
    localparam int S_TDATA_W = 3 * BYTE_W;
    localparam int S_TUSER_W = ACT_W;
    localparam int M_TDATA_W = BYTE_W;
    localparam int M_TUSER_W = STATUS_W;

    // Action codes carried on the input tuser
    localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

    // Status codes carried on the output tuser
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

    // Wire constants
    localparam logic [BYTE_W-1:0] SYNC_FF    = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_FD    = 8'hFD;
    localparam logic [BYTE_W-1:0] RSVD_BYTE  = 8'h00;
    localparam logic [BYTE_W-1:0] ID_RSVD_LO = 8'd253;
    localparam logic [BYTE_W-1:0] ID_RSVD_HI = 8'd255;
    localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h8005;
    localparam logic [15:0]       WIN_FF_FF  = 16'hFFFF;
    localparam logic [LEN_W-1:0]  LEN_EXTRA  = 16'd3;
    localparam logic [2:0]        HDR_LAST   = 3'd7;

    // Header byte positions
    localparam logic [2:0] HDR_SYNC0 = 3'd0;
    localparam logic [2:0] HDR_SYNC1 = 3'd1;
    localparam logic [2:0] HDR_SYNC2 = 3'd2;
    localparam logic [2:0] HDR_RSVD  = 3'd3;
    localparam logic [2:0] HDR_ID    = 3'd4;
    localparam logic [2:0] HDR_LEN_L = 3'd5;
    localparam logic [2:0] HDR_LEN_H = 3'd6;
    localparam logic [2:0] HDR_INST  = 3'd7;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_OVERFLOW,
        OP_START,
        OP_REJ_ID,
        OP_REJ_LEN,
        OP_HDR,
        OP_PARAM,
        OP_CRC_LO,
        OP_CRC_HI
    } t_op;

    typedef struct packed {
        logic take;   // latch the input beat
        logic fire;   // execute op on the latched item
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             id_bad;
        logic             too_long;
        logic             full;
        logic             hdr_last;
        logic             no_params;
        logic             param_done;
        logic             out_blocked;
    } t_sts;

    // CRC-16, poly 0x8005, MSB first, one byte
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### hw/rtl/sbpf_ctrl.sv
module sbpf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  sbpf_pkg::t_sts  i_sts,
    output sbpf_pkg::t_cmd  o_cmd
);
    import sbpf_pkg::*;

    typedef enum logic {
        S_WAIT,
        S_EXEC
    } t_state;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PARAMS,
        PH_CRC_LO,
        PH_CRC_HI
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    t_op    op;
    logic   has_result;
    logic   fire;

    // Decode the held item against the packet phase
    always_comb begin
        op      = OP_NONE;
        n_phase = r_phase;
        unique case (i_sts.action)
            ACT_LOAD: begin
                if (r_phase == PH_IDLE) begin
                    op = i_sts.full ? OP_OVERFLOW : OP_LOAD;
                end
            end
            ACT_SEND: begin
                if (r_phase == PH_IDLE) begin
                    priority if (i_sts.id_bad) begin
                        op = OP_REJ_ID;
                    end else if (i_sts.too_long) begin
                        op = OP_REJ_LEN;
                    end else begin
                        op      = OP_START;
                        n_phase = PH_HEADER;
                    end
                end
            end
            ACT_TICK: begin
                unique case (r_phase)
                    PH_HEADER: begin
                        op = OP_HDR;
                        if (i_sts.hdr_last) begin
                            n_phase = i_sts.no_params ? PH_CRC_LO : PH_PARAMS;
                        end
                    end
                    PH_PARAMS: begin
                        op = OP_PARAM;
                        if (i_sts.param_done) begin
                            n_phase = PH_CRC_LO;
                        end
                    end
                    PH_CRC_LO: begin
                        op      = OP_CRC_LO;
                        n_phase = PH_CRC_HI;
                    end
                    PH_CRC_HI: begin
                        op      = OP_CRC_HI;
                        n_phase = PH_IDLE;
                    end
                    default: begin
                        op = OP_NONE;
                    end
                endcase
            end
            default: begin
                op = OP_NONE;
            end
        endcase
    end

    // Ops that produce an output beat must wait for room
    always_comb begin
        unique case (op)
            OP_REJ_ID, OP_REJ_LEN, OP_HDR, OP_PARAM, OP_CRC_LO, OP_CRC_HI: has_result = 1'b1;
            default:                                                       has_result = 1'b0;
        endcase
    end

    assign fire = (r_state == S_EXEC) && (!has_result || !i_sts.out_blocked);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_WAIT:  if (i_s_tvalid) n_state = S_EXEC;
            S_EXEC:  if (fire) n_state = S_WAIT;
            default: n_state = S_WAIT;
        endcase
    end

    // Hold item state and packet phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WAIT;
            r_phase <= PH_IDLE;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_phase <= n_phase;
            end
        end
    end

    assign o_s_tready = (r_state == S_WAIT);
    assign o_cmd.take = i_s_tvalid && (r_state == S_WAIT);
    assign o_cmd.fire = fire;
    assign o_cmd.op   = op;

endmodule

### hw/rtl/sbpf_dpath.sv
module sbpf_dpath #(
    parameter int BUFFER_BYTES = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [sbpf_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic [sbpf_pkg::S_TUSER_W-1:0]  i_s_tuser,
    input  sbpf_pkg::t_cmd                  i_cmd,
    output sbpf_pkg::t_sts                  o_sts,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sbpf_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tlast,
    output logic [sbpf_pkg::M_TUSER_W-1:0]  o_m_tuser
);
    import sbpf_pkg::*;

    localparam int ADDR_W     = $clog2(BUFFER_BYTES);
    localparam int CNT_W      = $clog2(BUFFER_BYTES + 1);
    localparam int MAX_PARAMS = BUFFER_BYTES - 10;

    // Held item
    logic [ACT_W-1:0]  r_action;
    logic [BYTE_W-1:0] r_id;
    logic [BYTE_W-1:0] r_inst;
    logic [BYTE_W-1:0] r_pbyte;

    // Parameter store
    logic [BYTE_W-1:0] r_mem [BUFFER_BYTES];
    logic [BYTE_W-1:0] r_rd_data;

    // Load and emit state
    logic [CNT_W-1:0]  r_param_count;
    logic              r_too_long;
    logic [CNT_W-1:0]  r_stuff_count;
    logic [15:0]       r_load_window;
    logic [CNT_W-1:0]  r_emit_index;
    logic [15:0]       r_emit_window;
    logic              r_extra_fd;
    logic [CRC_W-1:0]  r_crc;
    logic [BYTE_W-1:0] r_held_id;
    logic [BYTE_W-1:0] r_held_inst;

    // Output register
    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic                r_out_last;
    logic [STATUS_W-1:0] r_out_status;

    logic [LEN_W-1:0]  pkt_len;
    logic [BYTE_W-1:0] hdr_byte;
    logic [BYTE_W-1:0] par_byte;
    logic              par_extra_n;
    logic [CNT_W-1:0]  par_index_n;
    logic [15:0]       par_window_n;
    logic [BYTE_W-1:0] emit_byte;
    logic [CRC_W-1:0]  crc_n;
    logic              do_op;
    logic              out_load;

    assign do_op = i_cmd.fire;

    // Header byte for the current position
    assign pkt_len = LEN_W'(r_param_count) + LEN_W'(r_stuff_count) + LEN_EXTRA;

    always_comb begin
        unique case (r_emit_index[2:0])
            HDR_SYNC0: hdr_byte = SYNC_FF;
            HDR_SYNC1: hdr_byte = SYNC_FF;
            HDR_SYNC2: hdr_byte = SYNC_FD;
            HDR_RSVD:  hdr_byte = RSVD_BYTE;
            HDR_ID:    hdr_byte = r_held_id;
            HDR_LEN_L: hdr_byte = pkt_len[7:0];
            HDR_LEN_H: hdr_byte = pkt_len[15:8];
            HDR_INST:  hdr_byte = r_held_inst;
            default:   hdr_byte = r_held_inst;
        endcase
    end

    // Parameter byte with stuffing after FF FF FD
    always_comb begin
        if (r_extra_fd) begin
            par_byte     = SYNC_FD;
            par_extra_n  = 1'b0;
            par_index_n  = r_emit_index;
            par_window_n = r_emit_window;
        end else begin
            par_byte     = r_rd_data;
            par_extra_n  = (r_emit_window == WIN_FF_FF) && (r_rd_data == SYNC_FD);
            par_index_n  = r_emit_index + CNT_W'(1);
            par_window_n = {r_emit_window[7:0], r_rd_data};
        end
    end

    // Select the wire byte and advance the CRC
    always_comb begin
        unique case (i_cmd.op)
            OP_HDR:    emit_byte = hdr_byte;
            OP_PARAM:  emit_byte = par_byte;
            OP_CRC_LO: emit_byte = r_crc[7:0];
            OP_CRC_HI: emit_byte = r_crc[15:8];
            default:   emit_byte = RSVD_BYTE;
        endcase
    end

    assign crc_n = crc16_byte(r_crc, emit_byte);

    always_comb begin
        unique case (i_cmd.op)
            OP_REJ_ID, OP_REJ_LEN, OP_HDR, OP_PARAM, OP_CRC_LO, OP_CRC_HI:
                out_load = do_op;
            default:
                out_load = 1'b0;
        endcase
    end

    // Latch the input beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_action <= i_s_tuser;
            r_id     <= i_s_tdata[BYTE_W-1:0];
            r_inst   <= i_s_tdata[2*BYTE_W-1:BYTE_W];
            r_pbyte  <= i_s_tdata[3*BYTE_W-1:2*BYTE_W];
        end
    end

    // Store write on load, registered read at the emit index
    always_ff @(posedge i_clk) begin
        if (do_op && (i_cmd.op == OP_LOAD)) begin
            r_mem[r_param_count[ADDR_W-1:0]] <= r_pbyte;
        end
        r_rd_data <= r_mem[r_emit_index[ADDR_W-1:0]];
    end

    // Hold id and instruction of the packet being sent
    always_ff @(posedge i_clk) begin
        if (do_op && (i_cmd.op == OP_START)) begin
            r_held_id   <= r_id;
            r_held_inst <= r_inst;
        end
    end

    // Advance load and emit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_param_count <= '0;
            r_too_long    <= 1'b0;
            r_stuff_count <= '0;
            r_load_window <= '0;
            r_emit_index  <= '0;
            r_emit_window <= '0;
            r_extra_fd    <= 1'b0;
            r_crc         <= '0;
        end else if (do_op) begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_param_count <= r_param_count + CNT_W'(1);
                    if ((r_load_window == WIN_FF_FF) && (r_pbyte == SYNC_FD)) begin
                        r_stuff_count <= r_stuff_count + CNT_W'(1);
                    end
                    r_load_window <= {r_load_window[7:0], r_pbyte};
                end
                OP_OVERFLOW: begin
                    r_too_long <= 1'b1;
                end
                OP_START: begin
                    r_emit_index  <= '0;
                    r_emit_window <= '0;
                    r_extra_fd    <= 1'b0;
                    r_crc         <= '0;
                end
                OP_REJ_LEN: begin
                    r_param_count <= '0;
                    r_too_long    <= 1'b0;
                    r_stuff_count <= '0;
                    r_load_window <= '0;
                end
                OP_HDR: begin
                    r_crc        <= crc_n;
                    r_emit_index <= (r_emit_index[2:0] == HDR_LAST) ? '0
                                                                    : r_emit_index + CNT_W'(1);
                end
                OP_PARAM: begin
                    r_crc         <= crc_n;
                    r_emit_index  <= par_index_n;
                    r_emit_window <= par_window_n;
                    r_extra_fd    <= par_extra_n;
                end
                OP_CRC_HI: begin
                    r_emit_index  <= '0;
                    r_emit_window <= '0;
                    r_extra_fd    <= 1'b0;
                    r_param_count <= '0;
                    r_too_long    <= 1'b0;
                    r_stuff_count <= '0;
                    r_load_window <= '0;
                end
                default: begin
                    r_crc <= r_crc;
                end
            endcase
        end
    end

    // Output register: fill on a result, drain on a taken beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_byte   <= emit_byte;
            r_out_last   <= (i_cmd.op == OP_CRC_HI) || (i_cmd.op == OP_REJ_ID)
                            || (i_cmd.op == OP_REJ_LEN);
            r_out_status <= (i_cmd.op == OP_REJ_ID)  ? ST_BAD_ID
                          : (i_cmd.op == OP_REJ_LEN) ? ST_TOO_LONG : ST_OK;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_status;

    // Status toward the controller
    assign o_sts.action      = r_action;
    assign o_sts.id_bad      = (r_id == ID_RSVD_LO) || (r_id == ID_RSVD_HI);
    assign o_sts.too_long    = r_too_long;
    assign o_sts.full        = (r_param_count >= CNT_W'(MAX_PARAMS));
    assign o_sts.hdr_last    = (r_emit_index[2:0] == HDR_LAST);
    assign o_sts.no_params   = (r_param_count == '0);
    assign o_sts.param_done  = (par_index_n >= r_param_count) && !par_extra_n;
    assign o_sts.out_blocked = r_out_valid && !i_m_tready;

endmodule

### hw/rtl/servo_bus_packet_framer.sv
// Channel   Dir  tdata (low bit up)                           tuser             tlast
// s_axis    in   packet_id[7:0], instruction[15:8],           action[1:0]       -
//                param_byte[23:16]
// m_axis    out  out_byte[7:0]                                status[1:0]       last_byte
//
// Every input beat is handled in two steps: accept, then execute; s_tready is low in
// the execute cycle. The execute cycle is held while a result beat still sits
// unread in the output register, so a stalled m side back-pressures s.
// The parameter store is read through a registered port at the emit index,
// so the read data is registered before the tick that uses it. Reset is synchronous,
// active low; the store itself is not cleared.
module servo_bus_packet_framer #(
    parameter int BUFFER_BYTES = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [sbpf_pkg::S_TDATA_W-1:0]  i_s_tdata,  // packet_id, instruction, param_byte
    input  logic [sbpf_pkg::S_TUSER_W-1:0]  i_s_tuser,  // action
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sbpf_pkg::M_TDATA_W-1:0]  o_m_tdata,  // out_byte
    output logic                            o_m_tlast,
    output logic [sbpf_pkg::M_TUSER_W-1:0]  o_m_tuser   // status
);
    import sbpf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sbpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sbpf_dpath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // One item in flight: an accepted beat blocks the next one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while an item is in execution");

    // A refusal is a single zero beat marked last
    a_reject_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ST_OK)) |-> (o_m_tlast && (o_m_tdata == '0)))
        else $error("refusal beat without last or with nonzero data");

    // Never overwrite an unread result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.fire && sts.out_blocked) |->
        (cmd.op == OP_NONE || cmd.op == OP_LOAD || cmd.op == OP_OVERFLOW
         || cmd.op == OP_START))
        else $error("result written over a stalled output beat");

    // End of packet empties the parameter buffer
    a_eop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.fire && (cmd.op == OP_CRC_HI)) |=> (sts.no_params && !sts.too_long))
        else $error("parameters left after end of packet");

endmodule
